// ===== sv/pgc_pkg.sv =====
// Package: shared types, register codes and reset constants of the gesture classifier.
package pgc_pkg;

  localparam int unsigned GRACE_SAMPLES_DEF = 4;

  localparam logic [15:0] MIN_DIST_RST  = 16'd50;
  localparam logic [15:0] MAX_DIST_RST  = 16'd300;
  localparam logic [15:0] LONG_HOLD_RST = 16'd600;
  localparam logic [15:0] DBL_CLICK_RST = 16'd400;
  localparam logic [15:0] VAL_LOWER_RST = 16'd0;
  localparam logic [15:0] VAL_UPPER_RST = 16'd100;
  localparam logic [15:0] PERIOD_RST    = 16'd50;
  localparam logic [15:0] TRAVEL_RST    = 16'd2000;
  localparam logic [15:0] VALUE_RST     = 16'd50;

  localparam logic [1:0] BUDGET_NONE    = 2'd0;
  localparam logic [1:0] BUDGET_MEASURE = 2'd1;
  localparam logic [1:0] BUDGET_DETECT  = 2'd2;

  typedef enum logic [2:0] {
    REG_MIN_DIST  = 3'd0,
    REG_MAX_DIST  = 3'd1,
    REG_LONG_HOLD = 3'd2,
    REG_DBL_CLICK = 3'd3,
    REG_VAL_LOWER = 3'd4,
    REG_VAL_UPPER = 3'd5,
    REG_PERIOD    = 3'd6,
    REG_TRAVEL    = 3'd7
  } pgc_reg_e;

  typedef struct packed {
    logic [15:0] distance;
    logic [31:0] now_ms;
  } pgc_in_t;

  typedef struct packed {
    logic               handled;
    logic               single_click;
    logic               double_click;
    logic               long_click;
    logic signed [15:0] adjust_value;
    logic [1:0]         budget_request;
  } pgc_out_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [17:0] m;
    logic signed [17:0] dv;
  } pgc_md_op_t;

endpackage

// ===== sv/pgc_stream_if.sv =====
// Interface: valid/ready channel carrying one request payload.
interface pgc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pgc_muldiv.sv =====
// Module: bit-serial signed multiply then truncating divide, x * m / dv.
module pgc_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pgc_pkg::pgc_md_op_t op_i,
  output logic                done_o,
  output logic signed [63:0]  quot_o
);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  localparam logic [6:0] MUL_LAST = 7'd16;
  localparam logic [6:0] DIV_LAST = 7'd63;

  md_state_e   state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d;
  logic [63:0] x_q, x_d;
  logic [16:0] m_q, m_d;
  logic [16:0] dv_q, dv_d;
  logic [63:0] acc_q, acc_d;
  logic [16:0] rem_q, rem_d;

  logic [63:0] x_abs;
  logic [17:0] m_abs, dv_abs;
  logic [17:0] rem_sh, rem_sub;

  assign x_abs   = op_i.x[63] ? 64'(-op_i.x) : 64'(op_i.x);
  assign m_abs   = op_i.m[17] ? 18'(-op_i.m) : 18'(op_i.m);
  assign dv_abs  = op_i.dv[17] ? 18'(-op_i.dv) : 18'(op_i.dv);
  assign rem_sh  = {rem_q, acc_q[63]};
  assign rem_sub = rem_sh - {1'b0, dv_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    x_d     = x_q;
    m_d     = m_q;
    dv_d    = dv_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          neg_d   = op_i.x[63] ^ op_i.m[17] ^ op_i.dv[17];
          x_d     = x_abs;
          m_d     = m_abs[16:0];
          dv_d    = dv_abs[16:0];
          acc_d   = '0;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        if (m_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d   = {x_q[62:0], 1'b0};
        m_d   = {1'b0, m_q[16:1]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        if (!rem_sub[17]) begin
          rem_d = rem_sub[16:0];
          acc_d = {acc_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh[16:0];
          acc_d = {acc_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == DIV_LAST) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    x_q   <= x_d;
    m_q   <= m_d;
    dv_q  <= dv_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 64'(-acc_q) : 64'(acc_q);

  a_done_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == MD_DIV))
    else $error("done without division step");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != MD_IDLE) |-> !done_d || (state_q == MD_DIV))
    else $error("done outside division");
  a_div_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MD_DIV) |-> (rem_q < dv_q))
    else $error("remainder not below divisor");

endmodule

// ===== sv/proximity_gesture_classifier.sv =====
// Top level: proximity gesture classifier with serial adjustment arithmetic.
//
// Requests arrive on req_i (distance in mm, millisecond timestamp); one
// result per request leaves on res_o (click flags, long-click level, the
// adjusted value and a budget request). Both channels use valid/ready.
// Registers are to be written through cfg_we_i / cfg_idx_i / cfg_data_i only
// while idle; the block itself does not enforce this. A request that does not
// move the adjusted value yields its result in the cycle after acceptance. A
// request during an anchored long click runs four multiply-divide passes
// on one bit-serial unit (17 multiply steps plus 64 divide steps each);
// that unit sets the rate.
// One request is in work at a time; the next is taken as soon as the
// output register is free or being emptied in the same cycle.
// A stalled receiver holds the result in the output register and blocks
// new requests. Reset clears all gesture state, loads register defaults
// and sets the adjusted value to its midpoint default.
module proximity_gesture_classifier #(
  parameter int unsigned GRACE_SAMPLES = pgc_pkg::GRACE_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  pgc_stream_if.sink           req_i,
  pgc_stream_if.source         res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_FIN  = 4'b0100,
    S_SPARE = 4'b1000
  } state_e;

  localparam logic [7:0] GRACE = 8'(GRACE_SAMPLES);

  state_e state_q, state_d;

  logic [15:0] min_q, max_q, hold_q, dcms_q, per_q, trav_q;
  logic signed [15:0] lo_q, up_q;

  logic        active_q, active_d;
  logic [31:0] st_q, st_d;
  logic        dpend_q, dpend_d;
  logic        sw_q, sw_d;
  logic [7:0]  lp_q, lp_d;
  logic [15:0] anchor_q, anchor_d;
  logic signed [31:0] resid_q, resid_d;
  logic signed [15:0] value_q, value_d;

  logic [1:0]  step_q, step_d;
  logic        md_start_q, md_start_d;
  logic signed [63:0] d_q, d_d, chain_q, chain_d, b_q, b_d;

  logic     out_valid_q, out_valid_d;
  pgc_pkg::pgc_out_t out_q, out_d;

  logic               accept;
  logic [15:0]        smp_dist;
  logic [31:0]        now;
  logic               in_win;
  logic [31:0]        elapsed;
  logic [31:0]        st_rel;
  logic               sc, dc;
  logic [1:0]         budget;
  logic               adj_go;
  logic signed [17:0] sv, sd, per_e, trav_e;
  logic signed [63:0] d_calc;
  logic signed [63:0] r_full, nv, up_w, lo_w;
  logic signed [31:0] r_sat;
  logic signed [15:0] nv_clamp;

  pgc_pkg::pgc_md_op_t md_op;
  logic               md_done;
  logic signed [63:0] md_quot;

  assign smp_dist = req_i.data.distance;
  assign now      = req_i.data.now_ms;
  assign accept   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || res_o.ready);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  assign sv     = {{2{up_q[15]}}, up_q} - {{2{lo_q[15]}}, lo_q};
  assign sd     = {2'b00, max_q} - {2'b00, min_q};
  assign per_e  = {2'b00, (per_q == '0) ? 16'd1 : per_q};
  assign trav_e = {2'b00, (trav_q == '0) ? 16'd1 : trav_q};
  assign d_calc = {{32{resid_q[31]}}, resid_q} + {48'd0, smp_dist} - {48'd0, anchor_q};

  assign in_win  = (smp_dist > min_q) && (smp_dist < max_q);
  assign elapsed = now - st_q;

  always_comb begin
    active_d = active_q;
    st_d     = st_q;
    dpend_d  = dpend_q;
    sw_d     = sw_q;
    lp_d     = lp_q;
    anchor_d = anchor_q;
    sc       = 1'b0;
    dc       = 1'b0;
    budget   = pgc_pkg::BUDGET_NONE;
    adj_go   = 1'b0;
    st_rel   = '0;
    if (in_win) begin
      if (active_q) begin
        if (elapsed > {16'd0, hold_q}) begin
          priority if (lp_q > 8'd1) begin
            lp_d = lp_q - 8'd1;
            if (lp_d == 8'd1) begin
              anchor_d = smp_dist;
            end
          end else if (lp_q == 8'd1) begin
            adj_go = (sv != '0) && (sd != '0);
          end else begin
            lp_d    = GRACE;
            budget  = pgc_pkg::BUDGET_MEASURE;
            dpend_d = 1'b0;
          end
        end
      end else begin
        if ((elapsed < {16'd0, dcms_q}) && (elapsed != '0)) begin
          dpend_d = 1'b1;
        end
        active_d = 1'b1;
        st_d     = now;
      end
    end else begin
      if (active_q) begin
        priority if (lp_q != '0) begin
          budget = pgc_pkg::BUDGET_DETECT;
          lp_d   = '0;
        end else if (dpend_q) begin
          dc      = 1'b1;
          dpend_d = 1'b0;
          sw_d    = 1'b0;
          st_d    = now - {16'd0, dcms_q};
        end else begin
          sw_d = 1'b1;
        end
        active_d = 1'b0;
      end
      st_rel = now - st_d;
      if (sw_d && (st_rel > {16'd0, dcms_q})) begin
        sc   = 1'b1;
        sw_d = 1'b0;
      end
    end
  end

  always_comb begin
    md_op = '0;
    unique case (step_q)
      2'd0: begin
        md_op.x = d_q;     md_op.m = sv;     md_op.dv = sd;
      end
      2'd1: begin
        md_op.x = chain_q; md_op.m = per_e;  md_op.dv = trav_e;
      end
      2'd2: begin
        md_op.x = chain_q; md_op.m = trav_e; md_op.dv = per_e;
      end
      2'd3: begin
        md_op.x = chain_q; md_op.m = sd;     md_op.dv = sv;
      end
      default: md_op = '0;
    endcase
  end

  pgc_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start_q),
    .op_i    (md_op),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  assign r_full = d_q - chain_q;
  assign up_w   = 64'(up_q);
  assign lo_w   = 64'(lo_q);
  assign nv     = b_q + 64'(value_q);

  always_comb begin
    priority if (r_full > 64'sd2147483647) begin
      r_sat = 32'sh7fffffff;
    end else if (r_full < -64'sd2147483648) begin
      r_sat = 32'sh80000000;
    end else begin
      r_sat = r_full[31:0];
    end
    priority if (nv > up_w) begin
      nv_clamp = up_q;
    end else if (nv < lo_w) begin
      nv_clamp = lo_q;
    end else begin
      nv_clamp = nv[15:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    md_start_d  = 1'b0;
    d_d         = d_q;
    chain_d     = chain_q;
    b_d         = b_q;
    resid_d     = resid_q;
    value_d     = value_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (adj_go) begin
            d_d        = d_calc;
            step_d     = 2'd0;
            md_start_d = 1'b1;
            state_d    = S_CALC;
          end else begin
            out_d.handled        = in_win;
            out_d.single_click   = sc;
            out_d.double_click   = dc;
            out_d.long_click     = (lp_d != '0);
            out_d.adjust_value   = value_q;
            out_d.budget_request = budget;
            out_valid_d          = 1'b1;
          end
        end
      end
      S_CALC: begin
        if (md_done) begin
          chain_d = md_quot;
          if (step_q == 2'd1) begin
            b_d = md_quot;
          end
          if (step_q == 2'd3) begin
            state_d = S_FIN;
          end else begin
            step_d     = step_q + 2'd1;
            md_start_d = 1'b1;
          end
        end
      end
      S_FIN: begin
        resid_d              = r_sat;
        value_d              = nv_clamp;
        out_d.handled        = 1'b1;
        out_d.single_click   = 1'b0;
        out_d.double_click   = 1'b0;
        out_d.long_click     = 1'b1;
        out_d.adjust_value   = nv_clamp;
        out_d.budget_request = pgc_pkg::BUDGET_NONE;
        out_valid_d          = 1'b1;
        state_d              = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= pgc_pkg::MIN_DIST_RST;
      max_q  <= pgc_pkg::MAX_DIST_RST;
      hold_q <= pgc_pkg::LONG_HOLD_RST;
      dcms_q <= pgc_pkg::DBL_CLICK_RST;
      lo_q   <= pgc_pkg::VAL_LOWER_RST;
      up_q   <= pgc_pkg::VAL_UPPER_RST;
      per_q  <= pgc_pkg::PERIOD_RST;
      trav_q <= pgc_pkg::TRAVEL_RST;
    end else if (cfg_we_i) begin
      unique case (pgc_pkg::pgc_reg_e'(cfg_idx_i))
        pgc_pkg::REG_MIN_DIST:  min_q  <= cfg_data_i;
        pgc_pkg::REG_MAX_DIST:  max_q  <= cfg_data_i;
        pgc_pkg::REG_LONG_HOLD: hold_q <= cfg_data_i;
        pgc_pkg::REG_DBL_CLICK: dcms_q <= cfg_data_i;
        pgc_pkg::REG_VAL_LOWER: lo_q   <= cfg_data_i;
        pgc_pkg::REG_VAL_UPPER: up_q   <= cfg_data_i;
        pgc_pkg::REG_PERIOD:    per_q  <= cfg_data_i;
        pgc_pkg::REG_TRAVEL:    trav_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      md_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      st_q        <= '0;
      dpend_q     <= 1'b0;
      sw_q        <= 1'b0;
      lp_q        <= '0;
      anchor_q    <= '0;
      resid_q     <= '0;
      value_q     <= pgc_pkg::VALUE_RST;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      md_start_q  <= md_start_d;
      out_valid_q <= out_valid_d;
      resid_q     <= resid_d;
      value_q     <= value_d;
      if (accept) begin
        active_q <= active_d;
        st_q     <= st_d;
        dpend_q  <= dpend_d;
        sw_q     <= sw_d;
        lp_q     <= lp_d;
        anchor_q <= anchor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    chain_q <= chain_d;
    b_q     <= b_d;
    out_q   <= out_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_i.ready)
    else $error("request taken while busy");
  a_fin_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> !out_valid_q)
    else $error("result overwritten");
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == S_CALC))
    else $error("serial unit done outside calculation");

endmodule

// ===== tb/pgc_tb_if.sv =====
// Testbench-side note: channels reuse the block's stream interface; this file holds tb constants.
`timescale 1ns / 1ps
package pgc_tb_pkg;
  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_ITEMS = 1720;
endpackage

// ===== tb/tb_top.sv =====
// Testbench top: drives gesture samples, predicts each result and checks it.
`timescale 1ns / 1ps
module tb_top;
  import pgc_pkg::*;
  import pgc_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  pgc_stream_if #(.T(pgc_in_t)) req_ch ();
  pgc_stream_if #(.T(pgc_out_t)) res_ch ();

  proximity_gesture_classifier dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req_i(req_ch.sink), .res_o(res_ch.source)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state
  logic [15:0] p_min, p_max, p_hold, p_dbl, p_per, p_trav;
  logic signed [15:0] p_lo, p_hi;
  bit pr_active, pr_dpend, pr_swait;
  logic [31:0] pr_start;
  int unsigned pr_phase;
  logic [15:0] pr_anchor;
  longint pr_resid;
  logic signed [15:0] pr_value;

  pgc_out_t expected_q[$];
  int errors = 0;
  int n_results = 0, n_single = 0, n_double = 0, n_long = 0;
  bit hold_off = 1'b0;
  bit quiet_sink = 1'b0;
  logic [31:0] clock_ms = 0;

  function automatic void reset_predictor();
    p_min = MIN_DIST_RST; p_max = MAX_DIST_RST; p_hold = LONG_HOLD_RST;
    p_dbl = DBL_CLICK_RST; p_lo = VAL_LOWER_RST; p_hi = VAL_UPPER_RST;
    p_per = PERIOD_RST; p_trav = TRAVEL_RST;
    pr_active = 0; pr_dpend = 0; pr_swait = 0; pr_start = 0; pr_phase = 0;
    pr_anchor = 0; pr_resid = 0; pr_value = VALUE_RST;
  endfunction

  function automatic void nudge_value(logic [15:0] smp_dist);
    longint sv, sd, p, t, d, a, b, r, nv;
    sv = longint'(p_hi) - longint'(p_lo);
    sd = longint'(p_max) - longint'(p_min);
    p = (p_per == 0) ? 1 : longint'(p_per);
    t = (p_trav == 0) ? 1 : longint'(p_trav);
    if (sv == 0 || sd == 0) return;
    d = longint'(smp_dist) + pr_resid - longint'(pr_anchor);
    a = d * sv / sd;
    b = a * p / t;
    r = b * t / p;
    r = r * sd / sv;
    r = d - r;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    pr_resid = r;
    nv = b + longint'(pr_value);
    if (nv > longint'(p_hi)) nv = p_hi;
    else if (nv < longint'(p_lo)) nv = p_lo;
    pr_value = nv[15:0];
  endfunction

  function automatic pgc_out_t classify_sample(pgc_in_t s);
    pgc_out_t o;
    logic [31:0] elapsed;
    o = '0;
    elapsed = s.now_ms - pr_start;
    if (s.distance > p_min && s.distance < p_max) begin
      if (pr_active) begin
        if (elapsed > {16'd0, p_hold}) begin
          if (pr_phase > 1) begin
            pr_phase--;
            if (pr_phase == 1) pr_anchor = s.distance;
          end else if (pr_phase == 1) begin
            nudge_value(s.distance);
          end else begin
            pr_phase = GRACE_SAMPLES_DEF;
            o.budget_request = BUDGET_MEASURE;
            pr_dpend = 0;
          end
        end
      end else begin
        if (elapsed < {16'd0, p_dbl} && elapsed > 0) pr_dpend = 1;
        pr_active = 1;
        pr_start = s.now_ms;
      end
      o.handled = 1;
    end else begin
      if (pr_active) begin
        if (pr_phase != 0) begin
          o.budget_request = BUDGET_DETECT;
          pr_phase = 0;
        end else if (pr_dpend) begin
          o.double_click = 1;
          pr_dpend = 0;
          pr_swait = 0;
          pr_start = s.now_ms - {16'd0, p_dbl};
        end else begin
          pr_swait = 1;
        end
        pr_active = 0;
      end
      if (pr_swait && (s.now_ms - pr_start) > {16'd0, p_dbl}) begin
        o.single_click = 1;
        pr_swait = 0;
      end
    end
    o.long_click = (pr_phase != 0);
    o.adjust_value = pr_value;
    return o;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic send_sample(logic [15:0] smp_dist, logic [31:0] now);
    pgc_in_t s;
    int gap;
    gap = quiet_sink ? 0 : short_gap();
    repeat (gap + 1) @(negedge clk_i);
    s.distance = smp_dist;
    s.now_ms = now;
    req_ch.valid <= 1'b1;
    req_ch.data <= s;
    do @(posedge clk_i); while (!req_ch.ready);
    expected_q.push_back(classify_sample(s));
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(pgc_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MIN_DIST: p_min = val;
      REG_MAX_DIST: p_max = val;
      REG_LONG_HOLD: p_hold = val;
      REG_DBL_CLICK: p_dbl = val;
      REG_VAL_LOWER: p_lo = val;
      REG_VAL_UPPER: p_hi = val;
      REG_PERIOD: p_per = val;
      default: p_trav = val;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic step_time(int unsigned ms);
    clock_ms += ms;
  endtask

  // one gesture: press for n samples at dt spacing, then release
  task automatic gesture(int unsigned n, int unsigned dt, bit moving);
    logic [15:0] lo, hi, d;
    lo = p_min + 16'd1;
    hi = (p_max > 0) ? p_max - 16'd1 : 16'd0;
    for (int i = 0; i < n; i++) begin
      if (hi >= lo) d = moving ? 16'($urandom_range(lo, hi)) : lo + (hi - lo) / 2;
      else d = 16'($urandom);
      send_sample(d, clock_ms);
      step_time(dt);
    end
    send_sample(($urandom_range(0, 1) != 0) ? 16'hFFFF : p_min, clock_ms);
    step_time(dt);
  endtask

  task automatic test_directed();
    clock_ms = 32'd1000;
    send_sample(16'd0, clock_ms);
    send_sample(16'hFFFF, clock_ms);
    send_sample(16'd50, clock_ms);
    send_sample(16'd300, clock_ms);
    gesture(1, 50, 0);
    step_time(800);
    send_sample(16'd400, clock_ms);
    gesture(1, 50, 0);
    step_time(100);
    gesture(1, 50, 0);
    step_time(500);
    gesture(14, 50, 1);
    clock_ms = 32'hFFFF_FF00;
    gesture(3, 60, 0);
    step_time(700);
    send_sample(16'd0, clock_ms);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    write_reg(REG_MIN_DIST, 16'd0);
    write_reg(REG_MAX_DIST, 16'hFFFF);
    write_reg(REG_LONG_HOLD, 16'd0);
    write_reg(REG_DBL_CLICK, 16'd1);
    write_reg(REG_VAL_LOWER, 16'h8000);
    write_reg(REG_VAL_UPPER, 16'h7FFF);
    write_reg(REG_PERIOD, 16'hFFFF);
    write_reg(REG_TRAVEL, 16'd1);
    for (int i = 0; i < 6; i++) gesture(10, 3, 1);
    wait_drained();
    write_reg(REG_VAL_UPPER, 16'h8000);
    write_reg(REG_PERIOD, 16'd0);
    write_reg(REG_TRAVEL, 16'd0);
    write_reg(REG_MAX_DIST, 16'd1);
    for (int i = 0; i < 4; i++) gesture(8, 5, 1);
    wait_drained();
    write_reg(REG_MAX_DIST, 16'd200);
    write_reg(REG_VAL_UPPER, 16'd20);
    write_reg(REG_VAL_LOWER, 16'd20);
    for (int i = 0; i < 4; i++) gesture(10, 2, 1);
    wait_drained();
    write_reg(REG_VAL_LOWER, 16'd100);
    write_reg(REG_VAL_UPPER, 16'hFF9C);
    write_reg(REG_LONG_HOLD, 16'hFFFF);
    write_reg(REG_DBL_CLICK, 16'hFFFF);
    for (int i = 0; i < 4; i++) gesture(6, 20000, 1);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ((sent % 300) == 0) begin
        wait_drained();
        write_reg(REG_MIN_DIST, 16'($urandom_range(0, 200)));
        write_reg(REG_MAX_DIST, p_min + 16'($urandom_range(2, 400)));
        write_reg(REG_LONG_HOLD, 16'($urandom_range(0, 300)));
        write_reg(REG_DBL_CLICK, 16'($urandom_range(1, 300)));
        write_reg(REG_VAL_LOWER, 16'($urandom_range(0, 65535)));
        write_reg(REG_VAL_UPPER, ($urandom_range(0, 3) == 0) ? p_lo : 16'($urandom));
        write_reg(REG_PERIOD, 16'($urandom_range(0, 200)));
        write_reg(REG_TRAVEL, 16'($urandom_range(0, 3000)));
      end
      if ($urandom_range(0, 9) < 8) begin
        int unsigned n;
        n = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 16);
        gesture(n, $urandom_range(1, 80), $urandom_range(0, 1));
        step_time($urandom_range(0, 400));
        sent += n + 1;
      end else begin
        send_sample(16'($urandom), ($urandom_range(0, 7) == 0) ? $urandom : clock_ms);
        step_time($urandom_range(0, 200));
        sent++;
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    quiet_sink = 1'b1;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 4; i++) gesture(6, 30, 1);
    join
    quiet_sink = 1'b0;
    wait_drained();
  endtask

  always begin
    int gap;
    @(negedge clk_i);
    if (hold_off) begin
      res_ch.ready <= 1'b0;
    end else if (!quiet_sink && $urandom_range(0, 3) == 0) begin
      gap = short_gap();
      res_ch.ready <= 1'b0;
      repeat (gap) @(negedge clk_i);
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pgc_out_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      n_results++;
      if (got.single_click) n_single++;
      if (got.double_click) n_double++;
      if (got.long_click) n_long++;
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.handled !== want.handled) begin
          $error("handled: expected %0d actual %0d", want.handled, got.handled); errors++;
        end
        if (got.single_click !== want.single_click) begin
          $error("single_click: expected %0d actual %0d", want.single_click,
                 got.single_click); errors++;
        end
        if (got.double_click !== want.double_click) begin
          $error("double_click: expected %0d actual %0d", want.double_click,
                 got.double_click); errors++;
        end
        if (got.long_click !== want.long_click) begin
          $error("long_click: expected %0d actual %0d", want.long_click, got.long_click);
          errors++;
        end
        if (got.adjust_value !== want.adjust_value) begin
          $error("adjust_value: expected %0d actual %0d", want.adjust_value,
                 got.adjust_value); errors++;
        end
        if (got.budget_request !== want.budget_request) begin
          $error("budget_request: expected %0d actual %0d", want.budget_request,
                 got.budget_request); errors++;
        end
      end
    end
  end

  initial begin
    #(64'd400_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_config_sweep();
    test_random();
    errors += expected_q.size();
    $display("Checked %0d results: %0d single, %0d double, %0d in long click.",
             n_results, n_single, n_double, n_long);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/pgc_pkg.sv
sv/pgc_stream_if.sv
sv/pgc_muldiv.sv
sv/proximity_gesture_classifier.sv
tb/pgc_tb_if.sv
tb/tb_top.sv
